// ===== hw/rtl/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths and item types for the 4x4 perspective point transform.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int unsigned FIX_W  = 32;  // Q format word
  localparam int unsigned SUM_W  = 66;  // three 64b products plus translation
  localparam int unsigned MAG_W  = 58;  // |column sum| >> FRAC_BITS, FRAC_BITS >= 8
  localparam int unsigned NUM_W  = 66;  // |v| << FRAC_BITS
  localparam int unsigned Q_W    = 32;  // quotient bits resolved by the divider
  localparam int unsigned NREG   = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned FIFO_D = 4;

  // front -> back transaction
  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [2:0]            neg;
    logic [MAG_W-1:0]      den;
    logic                  w_zero;
    logic [2:0][FIX_W-1:0] zval;   // clamped undivided values
    logic                  zsat;
  } ptp_item_t;

  // divider pipeline stage payload
  typedef struct packed {
    logic [2:0][MAG_W-1:0] rem;
    logic [2:0][Q_W-1:0]   nlo;
    logic [2:0][Q_W-1:0]   quo;
    logic [2:0]            ovf;
    logic [2:0]            neg;
    logic [MAG_W-1:0]      den;
    logic                  w_zero;
    logic [2:0][FIX_W-1:0] zval;
    logic                  zsat;
  } ptp_div_t;

  typedef struct packed {
    logic                  saturated;
    logic                  w_was_zero;
    logic [2:0][FIX_W-1:0] pt;     // z, y, x from high to low
  } ptp_res_t;

endpackage

// ===== hw/rtl/point_transform_4x4_perspective_top.sv =====
// ----------------------------------------------------------------------------
// point_transform_4x4_perspective_top
// Homogeneous 4x4 point transform with perspective divide, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one point per transaction: tdata = {z, y, x}, 32b each.
//   m_* returns one result per point: tdata = {z', y', x'} and tuser holds
//   w_was_zero (bit 0) and saturated (bit 1).
//   Matrix coefficients are written through cfg_*, register i at index i,
//   each holding columns 2P (low) and 2P+1 (high) of one row. Write only
//   while no point is in flight.
// Throughput: one point per cycle while m_tready stays high.
// Path: a point passes the product, sum and classify registers, the queue,
//   the divider input register, one divider stage per quotient bit and the
//   output register. The divider depth dominates the latency.
// Reset: coefficients return to the identity matrix, all pipes empty.
// Stall: with m_tready low the back end holds; the front keeps accepting
//   until the 4-entry queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module point_transform_4x4_perspective_top import ptp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [95:0]       s_tdata,     // x_in, y_in, z_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,     // x_out, y_out, z_out
  output logic [1:0]        m_tuser,     // w_was_zero, saturated
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [63:0]       cfg_wdata_i
);

  localparam logic [63:0] ONE_LO = 64'(64'd1 << FRAC_BITS);
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  logic [63:0]                reg_q [NREG];
  logic [3:0][3:0][FIX_W-1:0] coef;
  logic                       q_push, q_full, q_pop, q_empty;
  ptp_item_t                  item_w, item_r;
  ptp_res_t                   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[0] <= ONE_LO;
      reg_q[1] <= '0;
      reg_q[2] <= ONE_HI;
      reg_q[3] <= '0;
      reg_q[4] <= '0;
      reg_q[5] <= ONE_LO;
      reg_q[6] <= '0;
      reg_q[7] <= ONE_HI;
    end else if (cfg_we_i) begin
      reg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      coef[r][0] = reg_q[2*r][31:0];
      coef[r][1] = reg_q[2*r][63:32];
      coef[r][2] = reg_q[2*r+1][31:0];
      coef[r][3] = reg_q[2*r+1][63:32];
    end
  end

  ptp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .in_pt_i    (s_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (item_w)
  );

  ptp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (item_w),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (item_r)
  );

  ptp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_item_i    (item_r),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_res_o   (res)
  );

  assign m_tdata = res.pt;
  assign m_tuser = {res.saturated, res.w_was_zero};

endmodule

// ===== hw/rtl/ptp_front.sv =====
// ----------------------------------------------------------------------------
// ptp_front
// Accepts points, runs the matrix multiply and sums, and classifies each
// result (zero w, signs, divider operands) before queueing it.
// ----------------------------------------------------------------------------
module ptp_front import ptp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [3:0][3:0][FIX_W-1:0] coef_i,   // [row][col]
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0][FIX_W-1:0]      in_pt_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output ptp_item_t                  q_item_o
);

  logic en;
  logic v1_q, v2_q, v3_q;
  logic signed [63:0]      prod_q [4][3];
  logic signed [SUM_W-1:0] sum_q  [4];
  ptp_item_t               item_q, item_d;

  assign en         = !(v3_q && q_full_i);
  assign in_ready_o = en;
  assign q_push_o   = v3_q && en;
  assign q_item_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= $signed(in_pt_i[r]) * $signed(coef_i[r][c]);
        end
        sum_q[c] <= SUM_W'(prod_q[c][0]) + SUM_W'(prod_q[c][1]) + SUM_W'(prod_q[c][2])
                  + (SUM_W'($signed(coef_i[3][c])) <<< FRAC_BITS);
      end
      item_q <= item_d;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] w;
    logic [SUM_W-1:0]        mag;
    logic                    hi, lo;
    w = sum_q[3] >>> FRAC_BITS;
    mag = w[SUM_W-1] ? SUM_W'(-w) : SUM_W'(w);
    item_d        = '0;
    item_d.den    = mag[MAG_W-1:0];
    item_d.w_zero = (w == '0);
    for (int c = 0; c < 3; c++) begin
      v   = sum_q[c] >>> FRAC_BITS;
      mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      item_d.num[c] = NUM_W'(mag << FRAC_BITS);
      item_d.neg[c] = v[SUM_W-1] ^ w[SUM_W-1];
      // outside the 32b range when bits above 30 are not all sign copies
      hi = !v[SUM_W-1] && (|v[SUM_W-2:FIX_W-1]);
      lo =  v[SUM_W-1] && !(&v[SUM_W-2:FIX_W-1]);
      if (hi)      item_d.zval[c] = {1'b0, {(FIX_W-1){1'b1}}};
      else if (lo) item_d.zval[c] = {1'b1, {(FIX_W-1){1'b0}}};
      else         item_d.zval[c] = v[FIX_W-1:0];
      item_d.zsat = item_d.zsat | hi | lo;
    end
  end

endmodule

// ===== hw/rtl/ptp_fifo.sv =====
// ----------------------------------------------------------------------------
// ptp_fifo
// Short queue between the classifying front and the dividing back end.
// ----------------------------------------------------------------------------
module ptp_fifo import ptp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ptp_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ptp_item_t item_o
);

  localparam int unsigned PW = $clog2(FIFO_D);

  ptp_item_t         mem_q [FIFO_D];
  logic [PW-1:0]     wr_q, rd_q;
  logic [PW:0]       cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(FIFO_D));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== hw/rtl/ptp_back.sv =====
// ----------------------------------------------------------------------------
// ptp_back
// Pipelined restoring divider, one quotient bit per stage for x, y and z,
// followed by sign restore, clamping and the output register.
// ----------------------------------------------------------------------------
module ptp_back import ptp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  ptp_item_t q_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ptp_res_t  out_res_o
);

  function automatic ptp_div_t div_step(ptp_div_t s);
    ptp_div_t       n;
    logic [MAG_W:0] trial;
    n = s;
    for (int c = 0; c < 3; c++) begin
      trial    = {s.rem[c], s.nlo[c][Q_W-1]};
      n.nlo[c] = s.nlo[c] << 1;
      if (trial >= {1'b0, s.den}) begin
        n.rem[c] = MAG_W'(trial - {1'b0, s.den});
        n.quo[c] = {s.quo[c][Q_W-2:0], 1'b1};
      end else begin
        n.rem[c] = trial[MAG_W-1:0];
        n.quo[c] = {s.quo[c][Q_W-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  logic     en;
  logic     vld_q [Q_W+1];
  ptp_div_t bk_q  [Q_W+1];
  ptp_div_t init_d;
  logic     out_valid_q;
  ptp_res_t res_q, res_d;

  assign en          = !out_valid_q || out_ready_i;
  assign q_pop_o     = !q_empty_i && en;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    logic [MAG_W-1:0] top;
    init_d        = '0;
    init_d.den    = q_item_i.den;
    init_d.neg    = q_item_i.neg;
    init_d.w_zero = q_item_i.w_zero;
    init_d.zval   = q_item_i.zval;
    init_d.zsat   = q_item_i.zsat;
    for (int c = 0; c < 3; c++) begin
      top            = MAG_W'(q_item_i.num[c][NUM_W-1:Q_W]);
      // quotient of 2^32 or more clamps whatever the sign
      init_d.ovf[c]  = (top >= q_item_i.den);
      init_d.rem[c]  = top;
      init_d.nlo[c]  = q_item_i.num[c][Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Q_W; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= q_pop_o;
      for (int k = 0; k < Q_W; k++) vld_q[k+1] <= vld_q[k];
      out_valid_q <= vld_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bk_q[0] <= init_d;
      res_q   <= res_d;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) bk_q[k+1] <= div_step(bk_q[k]);
    end
  end

  always_comb begin
    ptp_div_t s;
    logic     sat;
    s     = bk_q[Q_W];
    res_d = '0;
    sat   = 1'b0;
    res_d.w_was_zero = s.w_zero;
    for (int c = 0; c < 3; c++) begin
      if (s.neg[c]) begin
        if (s.ovf[c] || (s.quo[c] > {1'b1, {(Q_W-1){1'b0}}})) begin
          res_d.pt[c] = {1'b1, {(FIX_W-1){1'b0}}};
          sat = 1'b1;
        end else begin
          res_d.pt[c] = FIX_W'(-s.quo[c]);
        end
      end else begin
        if (s.ovf[c] || s.quo[c][Q_W-1]) begin
          res_d.pt[c] = {1'b0, {(FIX_W-1){1'b1}}};
          sat = 1'b1;
        end else begin
          res_d.pt[c] = s.quo[c];
        end
      end
    end
    if (s.w_zero) begin
      res_d.pt        = s.zval;
      res_d.saturated = s.zsat;
    end else begin
      res_d.saturated = sat;
    end
  end

endmodule
